@@ src/qmt_pkg.sv @@
// Package for the qubit map table: field widths, operation and status codes,
// and the packed command, result and configuration types.
// Used by qmt_cfg, qmt_ctrl and qubit_map_table; depends on nothing.
package qmt_pkg;

    localparam int IDX_W      = 6;   // width of a qubit index
    localparam int CNT_W      = 7;   // counts up to 64 qubits
    localparam int MAP_W      = 7;   // map entry: mapped flag and real index
    localparam int MAPPED_BIT = 6;
    localparam int ST_W       = 2;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Operations
    localparam logic [MODE_W-1:0] MODE_INIT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REV    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SWAP   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_GET    = 3'd7;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_MAPPED   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_FREE  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_SWAP = 3'd4;

    // Qubit states
    localparam logic [ST_W-1:0] QS_NONE = 2'd0;
    localparam logic [ST_W-1:0] QS_INIT = 2'd1;
    localparam logic [ST_W-1:0] QS_LIVE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ST  = 2'd2;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = 7'd64;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  virt_index;
        logic [IDX_W-1:0]  real_index;
        logic [IDX_W-1:0]  other_real;
        logic [IDX_W-1:0]  new_real;
        logic              new_real_valid;
        logic [ST_W-1:0]   state_value;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]    index_result;
        logic                index_valid;
        logic [ST_W-1:0]     state_result;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Configuration as seen by the controller.
    typedef struct packed {
        logic [CNT_W-1:0] count;      // effective number of qubits
        logic             identity;
        logic [ST_W-1:0]  init_state;
    } cfg_t;

    // The unused state code reads as live.
    function automatic logic [ST_W-1:0] state_clamp(input logic [ST_W-1:0] s);
        state_clamp = (s == 2'd3) ? QS_LIVE : s;
    endfunction

endpackage

@@ src/qmt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; depends on nothing.
module qmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ src/qmt_cfg.sv @@
// Configuration registers of the qubit map table and the effective qubit count.
// Depends on qmt_pkg.
module qmt_cfg #(
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qmt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output qmt_pkg::cfg_t                    cfg
);

    logic [qmt_pkg::CNT_W-1:0] active_reg;
    logic                      identity_reg;
    logic [qmt_pkg::ST_W-1:0]  init_st_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= qmt_pkg::ACTIVE_RESET;
            identity_reg <= 1'b0;
            init_st_reg  <= qmt_pkg::QS_NONE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                qmt_pkg::CFG_ACTIVE:   active_reg   <= cfg_data[qmt_pkg::CNT_W-1:0];
                qmt_pkg::CFG_IDENTITY: identity_reg <= cfg_data[0];
                qmt_pkg::CFG_INIT_ST:  init_st_reg  <= cfg_data[qmt_pkg::ST_W-1:0];
                default:               ;
            endcase
        end
    end

    // The count never exceeds the storage depth.
    assign cfg.count      = (active_reg > qmt_pkg::CNT_W'(DEPTH)) ?
                            qmt_pkg::CNT_W'(DEPTH) : active_reg;
    assign cfg.identity   = identity_reg;
    assign cfg.init_state = init_st_reg;

endmodule

@@ src/qmt_ctrl.sv @@
// Sequencer of the qubit map table: holds the map and state memories and
// steps each command through reads, scans and write-backs.
// Depends on qmt_pkg and qmt_ram.
module qmt_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  qmt_pkg::item_t   cmd,
    input  qmt_pkg::cfg_t    cfg,
    output logic             busy,
    output logic             done,
    output qmt_pkg::result_t result
);

    localparam int AW    = $clog2(DEPTH);
    localparam int IDX_W = qmt_pkg::IDX_W;
    localparam int CNT_W = qmt_pkg::CNT_W;
    localparam int MAP_W = qmt_pkg::MAP_W;
    localparam int ST_W  = qmt_pkg::ST_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_FREE = 4'd4;
    localparam logic [3:0] S_SRD0 = 4'd5;
    localparam logic [3:0] S_SRD1 = 4'd6;
    localparam logic [3:0] S_SRD2 = 4'd7;
    localparam logic [3:0] S_SWR0 = 4'd8;
    localparam logic [3:0] S_SWR1 = 4'd9;

    logic [3:0]             state_reg, state_next;
    qmt_pkg::item_t         op_reg, op_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [CNT_W-1:0]       pidx_reg, pidx_next;
    logic                   f0_reg, f0_next, f1_reg, f1_next;
    logic [IDX_W-1:0]       v0_reg, v0_next, v1_reg, v1_next;
    logic [DEPTH-1:0]       used_reg, used_next;
    logic [ST_W-1:0]        st_r_reg, st_r_next, st_o_reg, st_o_next;
    logic [DEPTH-1:0]       map_vld_reg, st_vld_reg;
    logic                   mvq_reg, svq_reg;
    qmt_pkg::result_t       res_reg, res_next;
    logic                   done_reg, done_next;

    logic                   map_we, st_we;
    logic [AW-1:0]          map_waddr, map_raddr, st_waddr, st_raddr;
    logic [MAP_W-1:0]       map_wdata, map_rdata, map_q;
    logic [ST_W-1:0]        st_wdata, st_rdata, st_q;
    logic                   accept;

    qmt_ram #(.WIDTH(MAP_W), .DEPTH(DEPTH)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    qmt_ram #(.WIDTH(ST_W), .DEPTH(DEPTH)) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Entries never written since reset read as unmapped / none.
    assign map_q  = mvq_reg ? map_rdata : '0;
    assign st_q   = svq_reg ? st_rdata : '0;
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && (state_reg == S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        logic [MAP_W-1:0] e;
        logic             virt_ok, real_ok, other_ok, nreal_ok, bad;

        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        f0_next    = f0_reg;
        f1_next    = f1_reg;
        v0_next    = v0_reg;
        v1_next    = v1_reg;
        used_next  = used_reg;
        st_r_next  = st_r_reg;
        st_o_next  = st_o_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        map_we     = 1'b0;
        map_waddr  = '0;
        map_wdata  = '0;
        map_raddr  = '0;
        st_we      = 1'b0;
        st_waddr   = '0;
        st_wdata   = '0;
        st_raddr   = '0;
        e          = map_q;
        bad        = 1'b0;

        virt_ok  = {1'b0, cmd.virt_index} < cfg.count;
        real_ok  = {1'b0, cmd.real_index} < cfg.count;
        other_ok = {1'b0, cmd.other_real} < cfg.count;
        nreal_ok = {1'b0, cmd.new_real} < cfg.count;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = cmd;
                    cnt_next  = '0;
                    pend_next = 1'b0;
                    f0_next   = 1'b0;
                    f1_next   = 1'b0;
                    v0_next   = '0;
                    v1_next   = '0;
                    used_next = '0;
                    res_next  = '0;
                    case (cmd.mode)
                        qmt_pkg::MODE_INIT:
                        begin
                            state_next = S_INIT;
                        end
                        qmt_pkg::MODE_LOOKUP, qmt_pkg::MODE_ALLOC:
                        begin
                            if (!virt_ok)
                            begin
                                res_next.status = qmt_pkg::STAT_RANGE;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                map_raddr  = cmd.virt_index[AW-1:0];
                                state_next = S_RD;
                            end
                        end
                        qmt_pkg::MODE_WRITE:
                        begin
                            done_next = 1'b1;
                            if (!virt_ok || (cmd.new_real_valid && !nreal_ok))
                            begin
                                res_next.status = qmt_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                map_we    = 1'b1;
                                map_waddr = cmd.virt_index[AW-1:0];
                                map_wdata = cmd.new_real_valid ?
                                            {1'b1, cmd.new_real} : '0;
                            end
                        end
                        qmt_pkg::MODE_REV:
                        begin
                            if (!real_ok)
                            begin
                                res_next.status = qmt_pkg::STAT_RANGE;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        qmt_pkg::MODE_SWAP:
                        begin
                            if (!real_ok || !other_ok)
                            begin
                                res_next.status = qmt_pkg::STAT_RANGE;
                                done_next       = 1'b1;
                            end
                            else if (cmd.real_index == cmd.other_real)
                            begin
                                res_next.status = qmt_pkg::STAT_BAD_SWAP;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        qmt_pkg::MODE_SET:
                        begin
                            done_next = 1'b1;
                            if (!real_ok)
                            begin
                                res_next.status = qmt_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                st_we    = 1'b1;
                                st_waddr = cmd.real_index[AW-1:0];
                                st_wdata = qmt_pkg::state_clamp(cmd.state_value);
                            end
                        end
                        default:
                        begin
                            if (!real_ok)
                            begin
                                res_next.status = qmt_pkg::STAT_RANGE;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                st_raddr   = cmd.real_index[AW-1:0];
                                state_next = S_RD;
                            end
                        end
                    endcase
                end
            end

            S_INIT:
            begin
                map_we    = 1'b1;
                map_waddr = cnt_reg[AW-1:0];
                map_wdata = (cfg.identity && (cnt_reg < cfg.count)) ?
                            {1'b1, cnt_reg[IDX_W-1:0]} : '0;
                st_we     = 1'b1;
                st_waddr  = cnt_reg[AW-1:0];
                st_wdata  = qmt_pkg::state_clamp(cfg.init_state);
                if (cnt_reg == CNT_W'(DEPTH - 1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_RD:
            begin
                case (op_reg.mode)
                    qmt_pkg::MODE_LOOKUP:
                    begin
                        res_next.index_result = e[IDX_W-1:0];
                        res_next.index_valid  = e[qmt_pkg::MAPPED_BIT];
                        done_next             = 1'b1;
                        state_next            = S_IDLE;
                    end
                    qmt_pkg::MODE_ALLOC:
                    begin
                        if (e[qmt_pkg::MAPPED_BIT])
                        begin
                            res_next.status = qmt_pkg::STAT_MAPPED;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        res_next.state_result = st_q;
                        done_next             = 1'b1;
                        state_next            = S_IDLE;
                    end
                endcase
            end

            S_SCAN:
            begin
                // Process the entry read last cycle, keeping the lowest match.
                if (pend_reg && e[qmt_pkg::MAPPED_BIT])
                begin
                    if ((e[IDX_W-1:0] == op_reg.real_index) && !f0_reg)
                    begin
                        f0_next = 1'b1;
                        v0_next = pidx_reg[IDX_W-1:0];
                    end
                    if ((e[IDX_W-1:0] == op_reg.other_real) && !f1_reg)
                    begin
                        f1_next = 1'b1;
                        v1_next = pidx_reg[IDX_W-1:0];
                    end
                    if ({1'b0, e[IDX_W-1:0]} < CNT_W'(DEPTH))
                    begin
                        used_next[e[AW-1:0]] = 1'b1;
                    end
                end
                if (cnt_reg < cfg.count)
                begin
                    map_raddr = cnt_reg[AW-1:0];
                    pend_next = 1'b1;
                    pidx_next = cnt_reg;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && (cnt_reg >= cfg.count))
                begin
                    cnt_next = '0;
                    case (op_reg.mode)
                        qmt_pkg::MODE_REV:
                        begin
                            res_next.index_result = v0_reg;
                            res_next.index_valid  = f0_reg;
                            done_next             = 1'b1;
                            state_next            = S_IDLE;
                        end
                        qmt_pkg::MODE_ALLOC:
                        begin
                            state_next = S_FREE;
                        end
                        default:
                        begin
                            state_next = S_SRD0;
                        end
                    endcase
                end
            end

            S_FREE:
            begin
                if (cnt_reg >= cfg.count)
                begin
                    res_next.status = qmt_pkg::STAT_NO_FREE;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (!used_reg[cnt_reg[AW-1:0]])
                begin
                    map_we                = 1'b1;
                    map_waddr             = op_reg.virt_index[AW-1:0];
                    map_wdata             = {1'b1, cnt_reg[IDX_W-1:0]};
                    res_next.index_result = cnt_reg[IDX_W-1:0];
                    res_next.index_valid  = 1'b1;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_SRD0:
            begin
                st_raddr   = op_reg.real_index[AW-1:0];
                state_next = S_SRD1;
            end

            S_SRD1:
            begin
                st_r_next  = st_q;
                st_raddr   = op_reg.other_real[AW-1:0];
                state_next = S_SRD2;
            end

            S_SRD2:
            begin
                st_o_next = st_q;
                bad = (!f0_reg && !f1_reg) ||
                      (!f0_reg && (st_r_reg == qmt_pkg::QS_LIVE)) ||
                      (!f1_reg && (st_q == qmt_pkg::QS_LIVE));
                if (bad)
                begin
                    res_next.status = qmt_pkg::STAT_BAD_SWAP;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_SWR0;
                end
            end

            S_SWR0:
            begin
                map_we     = f0_reg;
                map_waddr  = v0_reg[AW-1:0];
                map_wdata  = {1'b1, op_reg.other_real};
                st_we      = 1'b1;
                st_waddr   = op_reg.real_index[AW-1:0];
                st_wdata   = st_o_reg;
                state_next = S_SWR1;
            end

            S_SWR1:
            begin
                map_we     = f1_reg;
                map_waddr  = v1_reg[AW-1:0];
                map_wdata  = {1'b1, op_reg.real_index};
                st_we      = 1'b1;
                st_waddr   = op_reg.other_real[AW-1:0];
                st_wdata   = st_r_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            map_vld_reg <= '0;
            st_vld_reg  <= '0;
            mvq_reg     <= 1'b0;
            svq_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
            mvq_reg   <= map_vld_reg[map_raddr];
            svq_reg   <= st_vld_reg[st_raddr];
            if (map_we)
            begin
                map_vld_reg[map_waddr] <= 1'b1;
            end
            if (st_we)
            begin
                st_vld_reg[st_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        pidx_reg <= pidx_next;
        f0_reg   <= f0_next;
        f1_reg   <= f1_next;
        v0_reg   <= v0_next;
        v1_reg   <= v1_next;
        used_reg <= used_next;
        st_r_reg <= st_r_next;
        st_o_reg <= st_o_next;
        res_reg  <= res_next;
    end

`ifndef SYNTHESIS
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE || start))
        else $error("result strobe without a command in flight");

    a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.status != qmt_pkg::STAT_OK) |->
        (res_reg.index_result == '0 && !res_reg.index_valid &&
         res_reg.state_result == '0))
        else $error("error result carries data");

    a_accept_progresses: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE || done_reg))
        else $error("accepted command neither started nor finished");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_FREE) |-> (cnt_reg <= cfg.count))
        else $error("scan counter ran past the active count");
`endif

endmodule

@@ src/qubit_map_table.sv @@
// Qubit map table: virtual-to-real map and per-qubit state in synchronous RAMs.
// Range errors, self-swaps, map writes and set state finish from idle; lookup, get
// state and allocate of a mapped qubit pass through a read state; reverse lookup
// scans the map; swap scans, reads both states and writes back unless refused;
// allocate scans and walks the marks; init writes every entry. One command at a time.
// Reset is asynchronous; untouched entries read unmapped / none, no clearing.
//
// Commands are accepted on start while busy is low. Each command yields one
// result beat, shown on result for the single cycle in which done is high;
// the receiver cannot stall it. busy drops in the same cycle as done, so the
// next command may follow at once.
//
// Scans of the map (reverse lookup, swap, allocate) read one map entry per
// cycle through the single read port of the map RAM, so their length is set
// by the active count. Allocate first marks every real qubit in use during
// that scan, then walks the marks from the lowest real qubit upwards.
// Configuration writes are always accepted and must only be made while idle.
module qubit_map_table #(
    parameter int MAX_QUBITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  qmt_pkg::item_t                 cmd,
    output logic                           done,
    output qmt_pkg::result_t               result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qmt_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Indices are six bits wide, so no more than 64 entries are reachable.
    localparam int DEPTH = (MAX_QUBITS < 64) ? MAX_QUBITS : 64;

    qmt_pkg::cfg_t cfg;

    qmt_cfg #(.DEPTH(DEPTH)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    qmt_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .cfg    (cfg),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

endmodule
